// ===== hw/rtl/emfb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event mailbox package
// Shared codes and types for the event mailbox with batch read.
// ----------------------------------------------------------------------------
package emfb_pkg;

   // Request function codes.
   localparam logic [1:0] FUNC_PUSH    = 2'd0;
   localparam logic [1:0] FUNC_READ    = 2'd1;
   localparam logic [1:0] FUNC_COMMAND = 2'd2;
   localparam logic [1:0] FUNC_NONE    = 2'd3;

   // Response kind codes.
   localparam logic [1:0] KIND_PUSH_STATUS = 2'd0;
   localparam logic [1:0] KIND_HEADER      = 2'd1;
   localparam logic [1:0] KIND_EVENT       = 2'd2;
   localparam logic [1:0] KIND_CMD_DONE    = 2'd3;

   // Field widths.
   localparam int WORD_W = 64;
   localparam int BYTE_W = 8;

   // Control register indexes.
   localparam int               CSR_INDEX_W     = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIN_ENABLED = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_CODE  = 8'd1;

   // One classified request waiting for the back end.
   typedef struct packed {
      logic [1:0]        func;
      logic [WORD_W-1:0] event_word;
      logic [BYTE_W-1:0] command_byte;
   } task_type;

   // Control register values seen by the back end.
   typedef struct packed {
      logic              pin_enabled;
      logic [BYTE_W-1:0] reset_code;
   } cfg_type;

endpackage

// ===== hw/rtl/emfb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module emfb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/emfb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event mailbox front end
// Accepts requests, drops the meaningless selector, and holds up to two
// requests for the back end.
// ----------------------------------------------------------------------------
module emfb_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_func,
   input  logic [emfb_pkg::WORD_W-1:0] req_event_word,
   input  logic [emfb_pkg::BYTE_W-1:0] req_command_byte,
   output logic                     task_valid,
   output emfb_pkg::task_type       task_head,
   input  logic                     task_pop
);
   import emfb_pkg::*;

   task_type   slot_ff [2];
   logic       head_ff, head_in;
   logic       tail_ff, tail_in;
   logic [1:0] count_ff, count_in;
   logic       accept;
   logic       enqueue;

   // A request is taken whenever the queue has room.
   assign busy    = (count_ff == 2'd2);
   assign accept  = start && !busy;
   assign enqueue = accept && (req_func != FUNC_NONE);

   assign task_valid = (count_ff != 2'd0);
   assign task_head  = slot_ff[head_ff];

   // Queue pointers and fill level.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (enqueue) begin
         tail_in = !tail_ff;
      end
      if (task_pop && task_valid) begin
         head_in = !head_ff;
      end
      unique case ({enqueue, task_pop && task_valid})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         tail_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Request payload storage.
   always_ff @(posedge clock) begin
      if (enqueue) begin
         slot_ff[tail_ff] <= '{func: req_func, event_word: req_event_word,
                               command_byte: req_command_byte};
      end
   end

endmodule

// ===== hw/rtl/emfb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event mailbox back end
// Owns the event ring and its pointers, carries out queued requests and
// drives the registered response ports.
// ----------------------------------------------------------------------------
module emfb_back #(
   parameter int DEPTH     = 64,
   parameter int BATCH_MAX = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   input  emfb_pkg::cfg_type           cfg,
   input  logic                        task_valid,
   input  emfb_pkg::task_type          task_head,
   output logic                        task_pop,
   output logic                        rsp_strobe,
   output logic [1:0]                  rsp_kind,
   output logic [emfb_pkg::WORD_W-1:0] rsp_payload,
   output logic                        rsp_accepted,
   output logic                        rsp_pending,
   output logic                        rsp_last
);
   import emfb_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(BATCH_MAX + 1);
   localparam int WW = (PW > CW) ? PW : CW;

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic              state_ff, state_in;
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     left_ff, left_in;
   logic              pend_ff, pend_in;

   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]        rsp_kind_ff, rsp_kind_in;
   logic [WORD_W-1:0] rsp_payload_ff, rsp_payload_in;
   logic              rsp_accepted_ff, rsp_accepted_in;
   logic              rsp_pending_ff, rsp_pending_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [PW-1:0]     wr_next;
   logic [PW-1:0]     rd_next;
   logic [PW:0]       span;
   logic [PW-1:0]     count;
   logic [WW-1:0]     count_w;
   logic [WW-1:0]     batch_w;
   logic [CW-1:0]     batch;
   logic              full;
   logic              code_hit;
   logic              ram_we;
   logic [WORD_W-1:0] ram_rdata;

   // Ring pointer arithmetic, wrapping at any depth.
   assign wr_next = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
   assign rd_next = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
   assign full    = (wr_next == rd_ptr_ff);

   // Queued count and the batch size of a read.
   always_comb begin
      if (wr_ptr_ff >= rd_ptr_ff) begin
         span = {1'b0, wr_ptr_ff} - {1'b0, rd_ptr_ff};
      end else begin
         span = {1'b0, wr_ptr_ff} + (PW + 1)'(DEPTH) - {1'b0, rd_ptr_ff};
      end
   end
   assign count    = span[PW-1:0];
   assign count_w  = WW'(count);
   assign batch_w  = (count_w > WW'(BATCH_MAX)) ? WW'(BATCH_MAX) : count_w;
   assign batch    = batch_w[CW-1:0];
   assign code_hit = (task_head.command_byte == cfg.reset_code);

   // Event storage; the read side always follows the oldest slot.
   emfb_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_ptr_ff),
      .wr_data (task_head.event_word),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rdata)
   );

   // Request execution.
   always_comb begin
      state_in        = state_ff;
      wr_ptr_in       = wr_ptr_ff;
      rd_ptr_in       = rd_ptr_ff;
      left_in         = left_ff;
      pend_in         = pend_ff;
      task_pop        = 1'b0;
      ram_we          = 1'b0;
      rsp_strobe_in   = 1'b0;
      rsp_kind_in     = KIND_PUSH_STATUS;
      rsp_payload_in  = '0;
      rsp_accepted_in = 1'b0;
      rsp_pending_in  = 1'b0;
      rsp_last_in     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (task_valid) begin
               task_pop      = 1'b1;
               rsp_strobe_in = 1'b1;
               unique case (task_head.func)
                  FUNC_PUSH: begin
                     // The ring is never empty after a push.
                     rsp_kind_in     = KIND_PUSH_STATUS;
                     rsp_accepted_in = !full;
                     rsp_pending_in  = cfg.pin_enabled;
                     rsp_last_in     = 1'b1;
                     if (!full) begin
                        ram_we    = 1'b1;
                        wr_ptr_in = wr_next;
                     end
                  end
                  FUNC_READ: begin
                     rsp_kind_in    = KIND_HEADER;
                     rsp_payload_in = WORD_W'(batch);
                     rsp_pending_in = cfg.pin_enabled && (count_w != batch_w);
                     rsp_last_in    = (batch == '0);
                     pend_in        = cfg.pin_enabled && (count_w != batch_w);
                     if (batch != '0) begin
                        left_in   = batch;
                        rd_ptr_in = rd_next;
                        state_in  = ST_DRAIN;
                     end
                  end
                  FUNC_COMMAND: begin
                     rsp_kind_in    = KIND_CMD_DONE;
                     rsp_pending_in = cfg.pin_enabled && !code_hit &&
                                      (wr_ptr_ff != rd_ptr_ff);
                     rsp_last_in    = 1'b1;
                     if (code_hit) begin
                        wr_ptr_in = '0;
                        rd_ptr_in = '0;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b0;
                  end
               endcase
            end
         end
         ST_DRAIN: begin
            // One word per cycle; the next slot is fetched while this one goes out.
            rsp_strobe_in  = 1'b1;
            rsp_kind_in    = KIND_EVENT;
            rsp_payload_in = ram_rdata;
            rsp_pending_in = pend_ff;
            rsp_last_in    = (left_ff == CW'(1));
            left_in        = left_ff - CW'(1);
            if (left_ff == CW'(1)) begin
               state_in = ST_IDLE;
            end else begin
               rd_ptr_in = rd_next;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         left_ff       <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         left_ff       <= left_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      rsp_kind_ff     <= rsp_kind_in;
      rsp_payload_ff  <= rsp_payload_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_pending_ff  <= rsp_pending_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_payload  = rsp_payload_ff;
   assign rsp_accepted = rsp_accepted_ff;
   assign rsp_pending  = rsp_pending_ff;
   assign rsp_last     = rsp_last_ff;

   // A drain cycle always produces an event word.
   a_drain_emits: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |=> rsp_strobe_ff && rsp_kind_ff == KIND_EVENT)
      else $error("drain cycle produced no event word");

   // The final response of a request leaves the back end idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_last_ff) |-> state_ff == ST_IDLE)
      else $error("last response while still draining");

   // A header never announces more than one batch.
   a_header_size: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_kind_ff == KIND_HEADER) |->
         rsp_payload_ff <= WORD_W'(BATCH_MAX))
      else $error("header count above batch limit");

   // Ring pointers stay inside the ring.
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (PW + 1)'(wr_ptr_ff) < (PW + 1)'(DEPTH) && (PW + 1)'(rd_ptr_ff) < (PW + 1)'(DEPTH))
      else $error("ring pointer out of range");

endmodule

// ===== hw/rtl/event_mailbox_fifo_batch_read.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event mailbox with batch read
// Ring queue of 64-bit event words with push, batch drain and clear command.
// ----------------------------------------------------------------------------
// A request is taken on any cycle with start high and busy low; busy rises
// only when two requests are already waiting for the back end. A push or a
// command gets one response, and a read that returns N words (N at most
// BATCH_MAX) gets a header and then the words from the event RAM, which
// delivers one registered word per cycle. Responses are registered and
// appear in the cycle after the back end takes the request, one per cycle
// with rsp_strobe high for exactly one cycle, and must be captured then
// because the receiver cannot stall them. Ring slots are never read before
// they are written, so no clearing pass follows reset. Control registers may
// be written only while the mailbox is idle; csr_ready is always high.
module event_mailbox_fifo_batch_read #(
   parameter int DEPTH     = 64,
   parameter int BATCH_MAX = 6
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_func,
   input  logic [emfb_pkg::WORD_W-1:0]      req_event_word,
   input  logic [emfb_pkg::BYTE_W-1:0]      req_command_byte,
   output logic                             rsp_strobe,
   output logic [1:0]                       rsp_kind,
   output logic [emfb_pkg::WORD_W-1:0]      rsp_payload,
   output logic                             rsp_accepted,
   output logic                             rsp_pending,
   output logic                             rsp_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [emfb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [emfb_pkg::BYTE_W-1:0]      csr_data
);
   import emfb_pkg::*;

   logic              pin_enabled_ff, pin_enabled_in;
   logic [BYTE_W-1:0] reset_code_ff, reset_code_in;
   cfg_type           cfg;
   logic              task_valid;
   task_type          task_head;
   logic              task_pop;

   // Control registers.
   assign csr_ready = 1'b1;

   always_comb begin
      pin_enabled_in = pin_enabled_ff;
      reset_code_in  = reset_code_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PIN_ENABLED: pin_enabled_in = csr_data[0];
            CSR_RESET_CODE:  reset_code_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pin_enabled_ff <= 1'b1;
         reset_code_ff  <= 8'd3;
      end else begin
         pin_enabled_ff <= pin_enabled_in;
         reset_code_ff  <= reset_code_in;
      end
   end

   assign cfg = '{pin_enabled: pin_enabled_ff, reset_code: reset_code_ff};

   // Front end: request intake and queue.
   emfb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_event_word   (req_event_word),
      .req_command_byte (req_command_byte),
      .task_valid       (task_valid),
      .task_head        (task_head),
      .task_pop         (task_pop)
   );

   // Back end: ring, execution and responses.
   emfb_back #(
      .DEPTH     (DEPTH),
      .BATCH_MAX (BATCH_MAX)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .task_valid   (task_valid),
      .task_head    (task_head),
      .task_pop     (task_pop),
      .rsp_strobe   (rsp_strobe),
      .rsp_kind     (rsp_kind),
      .rsp_payload  (rsp_payload),
      .rsp_accepted (rsp_accepted),
      .rsp_pending  (rsp_pending),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== bench/tb_event_mailbox_fifo_batch_read.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event mailbox with batch read testbench
// Sends push, read and command requests and checks every response against
// a behavioral mirror of the ring queue. Configuration changes happen only
// while the mailbox is idle. Idle gaps on the request side vary by phase.
// ----------------------------------------------------------------------------
module tb_event_mailbox_fifo_batch_read;
   import emfb_pkg::*;

   localparam int RING_DEPTH     = 64;
   localparam int BATCH_LIMIT    = 6;
   localparam int SETTLE_CYCLES  = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 10;
   localparam int RESET_CYCLES   = 6;

   localparam logic [BYTE_W-1:0]      CLEAR_CODE_AT_RESET = 8'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX     = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOP_INDEX       = 8'hFF;

   // One response as the mailbox should present it.
   typedef struct packed {
      logic [1:0]        kind;
      logic [WORD_W-1:0] payload;
      logic              accepted;
      logic              pending;
      logic              last;
   } mailbox_answer_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [1:0]             req_func;
   logic [WORD_W-1:0]      req_event_word;
   logic [BYTE_W-1:0]      req_command_byte;
   logic                   rsp_strobe;
   logic [1:0]             rsp_kind;
   logic [WORD_W-1:0]      rsp_payload;
   logic                   rsp_accepted;
   logic                   rsp_pending;
   logic                   rsp_last;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [BYTE_W-1:0]      csr_data;

   // Mirror of the mailbox state and its control registers.
   logic [WORD_W-1:0] mirror_ring [RING_DEPTH];
   int unsigned       mirror_wr;
   int unsigned       mirror_rd;
   logic              mirror_pin_en;
   logic [BYTE_W-1:0] mirror_clear_code;

   mailbox_answer_type awaited_answers [$];
   int unsigned        error_count     = 0;
   int unsigned        quiet_cycles    = 0;
   int unsigned        sender_idle_pct = 0;

   event_mailbox_fifo_batch_read #(
      .DEPTH     (RING_DEPTH),
      .BATCH_MAX (BATCH_LIMIT)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_event_word   (req_event_word),
      .req_command_byte (req_command_byte),
      .rsp_strobe       (rsp_strobe),
      .rsp_kind         (rsp_kind),
      .rsp_payload      (rsp_payload),
      .rsp_accepted     (rsp_accepted),
      .rsp_pending      (rsp_pending),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_error(input string what);
      if (error_count < MAX_REPORTS)
         $display("ERROR @%0t: %s", $realtime, what);
      error_count++;
   endtask

   function automatic int unsigned queued_words();
      return (mirror_wr + RING_DEPTH - mirror_rd) % RING_DEPTH;
   endfunction

   function automatic mailbox_answer_type make_answer(input logic [1:0] kind,
                                                      input logic [WORD_W-1:0] payload,
                                                      input logic accepted,
                                                      input logic last);
      mailbox_answer_type a;
      a.kind     = kind;
      a.payload  = payload;
      a.accepted = accepted;
      a.pending  = 1'b0;
      a.last     = last;
      return a;
   endfunction

   // Apply one accepted request to the mirror and queue the responses it causes.
   function automatic void predict_mailbox(input logic [1:0] func,
                                           input logic [WORD_W-1:0] word,
                                           input logic [BYTE_W-1:0] cmd);
      mailbox_answer_type answers [$];
      int unsigned        next_wr;
      int unsigned        count;
      int unsigned        i;
      logic               level;
      case (func)
         FUNC_PUSH: begin
            next_wr = (mirror_wr + 1) % RING_DEPTH;
            if (next_wr != mirror_rd) begin
               mirror_ring[mirror_wr] = word;
               mirror_wr = next_wr;
               answers.push_back(make_answer(KIND_PUSH_STATUS, '0, 1'b1, 1'b1));
            end else begin
               answers.push_back(make_answer(KIND_PUSH_STATUS, '0, 1'b0, 1'b1));
            end
         end
         FUNC_READ: begin
            count = queued_words();
            if (count > BATCH_LIMIT)
               count = BATCH_LIMIT;
            answers.push_back(make_answer(KIND_HEADER, WORD_W'(count), 1'b0, count == 0));
            for (i = 0; i < count; i++) begin
               answers.push_back(make_answer(KIND_EVENT, mirror_ring[mirror_rd], 1'b0,
                                             i + 1 == count));
               mirror_rd = (mirror_rd + 1) % RING_DEPTH;
            end
         end
         FUNC_COMMAND: begin
            if (cmd == mirror_clear_code) begin
               mirror_wr = 0;
               mirror_rd = 0;
            end
            answers.push_back(make_answer(KIND_CMD_DONE, '0, 1'b0, 1'b1));
         end
         default: begin
            // The unused selector is ignored entirely.
         end
      endcase
      // The pin level reflects the state after the whole request.
      level = (mirror_wr != mirror_rd) && mirror_pin_en;
      foreach (answers[k]) begin
         answers[k].pending = level;
         awaited_answers.push_back(answers[k]);
      end
   endfunction

   // Present one request, wait for it to be taken, then predict its responses.
   task automatic send_request(input logic [1:0] func,
                               input logic [WORD_W-1:0] word,
                               input logic [BYTE_W-1:0] cmd);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      start            <= 1'b1;
      req_func         <= func;
      req_event_word   <= word;
      req_command_byte <= cmd;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      predict_mailbox(func, word, cmd);
   endtask

   // Stop sending, wait for every response, then let the back end go quiet.
   task automatic drain_and_settle();
      @(negedge clock);
      start <= 1'b0;
      while (awaited_answers.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [BYTE_W-1:0] data);
      drain_and_settle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      // Only the defined indexes change anything; values keep their low bits.
      case (index)
         CSR_PIN_ENABLED: mirror_pin_en = data[0];
         CSR_RESET_CODE:  mirror_clear_code = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // A read on an empty queue gives a lone header with count zero.
   task automatic test_empty_read();
      send_request(FUNC_READ, '0, '0);
   endtask

   // Extreme words go in and come out oldest first, split across two batches.
   task automatic test_push_read_order();
      send_request(FUNC_PUSH, 64'h0000_0000_0000_0000, 8'h00);
      send_request(FUNC_PUSH, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
      send_request(FUNC_PUSH, 64'hAAAA_AAAA_AAAA_AAAA, 8'hAA);
      send_request(FUNC_PUSH, 64'h5555_5555_5555_5555, 8'h55);
      repeat (3) send_request(FUNC_PUSH, {$urandom, $urandom}, 8'h00);
      send_request(FUNC_READ, '0, '0);
      send_request(FUNC_READ, '0, '0);
   endtask

   // A foreign command byte leaves the queue alone; the clear code empties it.
   task automatic test_commands();
      send_request(FUNC_PUSH, {$urandom, $urandom}, 8'h00);
      send_request(FUNC_COMMAND, '0, mirror_clear_code ^ 8'h01);
      send_request(FUNC_COMMAND, '1, mirror_clear_code);
      send_request(FUNC_READ, '0, '0);
   endtask

   // The unused selector gives nothing, even with the clear code on its byte.
   task automatic test_unused_selector();
      send_request(FUNC_PUSH, {$urandom, $urandom}, 8'h00);
      send_request(FUNC_NONE, '1, mirror_clear_code);
      send_request(FUNC_READ, '0, '0);
   endtask

   // With the pin disabled pending stays low; only bit zero of the value counts.
   task automatic test_pin_enable();
      write_register(CSR_PIN_ENABLED, 8'hFE);
      send_request(FUNC_PUSH, {$urandom, $urandom}, 8'h00);
      send_request(FUNC_PUSH, {$urandom, $urandom}, 8'h00);
      write_register(CSR_PIN_ENABLED, 8'h01);
      send_request(FUNC_PUSH, {$urandom, $urandom}, 8'h00);
      send_request(FUNC_READ, '0, '0);
   endtask

   // Clear code at both extremes; writes to undefined indexes are ignored.
   task automatic test_clear_code();
      write_register(CSR_RESET_CODE, 8'h00);
      send_request(FUNC_PUSH, {$urandom, $urandom}, 8'h00);
      send_request(FUNC_COMMAND, '0, CLEAR_CODE_AT_RESET);
      send_request(FUNC_COMMAND, '0, 8'h00);
      write_register(CSR_RESET_CODE, 8'hFF);
      send_request(FUNC_PUSH, {$urandom, $urandom}, 8'h00);
      write_register(CSR_SPARE_INDEX, 8'($urandom_range(255)));
      write_register(CSR_TOP_INDEX, 8'($urandom_range(255)));
      write_register(CSR_INDEX_W'($urandom_range(3, 254)), 8'($urandom_range(255)));
      send_request(FUNC_COMMAND, '0, 8'hFF);
   endtask

   // Fill the ring to capacity, push past it, then drain it batch by batch.
   task automatic test_queue_full();
      sender_idle_pct = 28;
      while (queued_words() < RING_DEPTH - 1)
         send_request(FUNC_PUSH, {$urandom, $urandom}, 8'($urandom_range(255)));
      repeat (3) send_request(FUNC_PUSH, {$urandom, $urandom}, 8'($urandom_range(255)));
      while (queued_words() != 0)
         send_request(FUNC_READ, {$urandom, $urandom}, 8'($urandom_range(255)));
      send_request(FUNC_READ, '0, '0);
      send_request(FUNC_PUSH, {$urandom, $urandom}, 8'($urandom_range(255)));
   endtask

   // One random request, biased toward pushes or toward reads.
   task automatic send_random_item(input bit fill_bias);
      int unsigned       pick;
      int unsigned       push_share;
      int unsigned       read_share;
      logic [WORD_W-1:0] word;
      logic [BYTE_W-1:0] cmd;
      push_share = fill_bias ? 85 : 35;
      read_share = fill_bias ? 8 : 55;
      pick = $urandom_range(99);
      word = {$urandom, $urandom};
      cmd  = 8'($urandom_range(255));
      if (pick < push_share) begin
         send_request(FUNC_PUSH, word, cmd);
      end else if (pick < push_share + read_share) begin
         send_request(FUNC_READ, word, cmd);
      end else if (pick < 97) begin
         if ($urandom_range(2) == 0)
            cmd = mirror_clear_code;
         send_request(FUNC_COMMAND, word, cmd);
      end else begin
         send_request(FUNC_NONE, word, cmd);
      end
   endtask

   // Mixed traffic over several settings and request-side idle rates.
   task automatic test_random_traffic();
      int unsigned phase;
      int unsigned n;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               write_register(CSR_RESET_CODE, 8'($urandom_range(255)));
               write_register(CSR_PIN_ENABLED, 8'h01);
               sender_idle_pct = 0;
            end
            1: begin
               write_register(CSR_RESET_CODE, 8'h00);
               write_register(CSR_PIN_ENABLED, 8'h00);
               sender_idle_pct = 78;
            end
            2: begin
               write_register(CSR_RESET_CODE, 8'hFF);
               write_register(CSR_PIN_ENABLED, 8'h01);
               sender_idle_pct = 28;
            end
            default: begin
               write_register(CSR_RESET_CODE, 8'($urandom_range(255)));
               sender_idle_pct = 78;
            end
         endcase
         for (n = 0; n < 36; n++)
            send_random_item((n / 25) % 2 == 0);
      end
   endtask

   // Compare each response with the oldest waiting expectation.
   always @(posedge clock) begin : response_check
      mailbox_answer_type want;
      if (!reset && rsp_strobe) begin
         if (awaited_answers.size() == 0) begin
            report_error($sformatf("unexpected response kind %0d payload %h last %b",
                                   rsp_kind, rsp_payload, rsp_last));
         end else begin
            want = awaited_answers.pop_front();
            if (rsp_kind !== want.kind || rsp_payload !== want.payload ||
                rsp_accepted !== want.accepted || rsp_pending !== want.pending ||
                rsp_last !== want.last)
               report_error($sformatf({"response mismatch: expected kind %0d payload %h ",
                                       "acc %b pend %b last %b, got kind %0d payload %h ",
                                       "acc %b pend %b last %b"},
                                      want.kind, want.payload, want.accepted,
                                      want.pending, want.last, rsp_kind, rsp_payload,
                                      rsp_accepted, rsp_pending, rsp_last));
         end
      end
   end

   // Stop the run if nothing moves on any channel for too long.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** event_mailbox_fifo_batch_read: FAILED **");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_func         = FUNC_PUSH;
      req_event_word   = '0;
      req_command_byte = '0;
      csr_valid        = 1'b0;
      csr_index        = CSR_PIN_ENABLED;
      csr_data         = '0;
      mirror_wr         = 0;
      mirror_rd         = 0;
      mirror_pin_en     = 1'b1;
      mirror_clear_code = CLEAR_CODE_AT_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_read();
      test_push_read_order();
      test_commands();
      test_unused_selector();
      test_pin_enable();
      test_clear_code();
      test_queue_full();
      test_random_traffic();

      drain_and_settle();
      if (error_count == 0)
         $display("** event_mailbox_fifo_batch_read: PASSED **");
      else
         $display("** event_mailbox_fifo_batch_read: FAILED **");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/emfb_pkg.sv
hw/rtl/emfb_ram.sv
hw/rtl/emfb_front.sv
hw/rtl/emfb_back.sv
hw/rtl/event_mailbox_fifo_batch_read.sv
bench/tb_event_mailbox_fifo_batch_read.sv
